@@ design/stm_pkg.sv @@
// Package for the sparse MTTKRP engine: constants, codes and arithmetic helpers.
// No dependencies.
package stm_pkg;

    localparam int ROWS_MAX_DEF  = 1024;
    localparam int RANK_MAX_DEF  = 16;
    localparam int MODES_MAX_DEF = 4;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_NZ    = 2'd1,
        OP_READ  = 2'd2,
        OP_CLEAR = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        REG_NUM_MODES     = 2'd0,
        REG_TARGET_MODE   = 2'd1,
        REG_RANK          = 2'd2,
        REG_PRODUCT_ORDER = 2'd3
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_RDREQ,
        ST_FACT,
        ST_MUL,
        ST_ACC,
        ST_READ,
        ST_OUT
    } state_t;

    // Saturate a 64-bit signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Shift a Q32.32 product down to Q16.16 toward minus infinity, then saturate.
    function automatic logic signed [31:0] qscale(input logic signed [63:0] p);
        logic signed [63:0] q;
        q = p >>> 16;
        return sat32(q);
    endfunction

endpackage

@@ design/stm_if.sv @@
// Valid/ready channel interfaces for the sparse MTTKRP engine.
// No dependencies.
interface stm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  op;
    logic [1:0]  factor_select;
    logic [3:0]  column;
    logic [9:0]  coord_0;
    logic [9:0]  coord_1;
    logic [9:0]  coord_2;
    logic [9:0]  coord_3;
    logic signed [31:0] value;
    modport source (output valid, op, factor_select, column, coord_0, coord_1, coord_2,
                    coord_3, value, input ready);
    modport sink   (input valid, op, factor_select, column, coord_0, coord_1, coord_2,
                    coord_3, value, output ready);
endinterface

interface stm_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] read_value;
    modport source (output valid, read_value, input ready);
    modport sink   (input valid, read_value, output ready);
endinterface

@@ design/sparse_tensor_mttkrp.sv @@
// Sparse MTTKRP engine, top level: factor and output memories with a sequencer.
// Depends on stm_pkg and the stm_in_if / stm_out_if interfaces.
//
// Rate: after reset the output memory is cleared one entry a cycle, so no item is
// accepted until that pass ends. A read passes through accept, memory read and result
// register, and a clear writes one output entry a cycle. A nonzero does nothing with
// rank 0; otherwise every factor element comes through the single factor memory read
// port and is multiplied in one at a time, and each output column is read and written
// back through the output memory. Output items leave through a register, so a
// waiting result does not block a following load or nonzero.
module sparse_tensor_mttkrp
#(
    parameter int ROWS_MAX  = stm_pkg::ROWS_MAX_DEF,
    parameter int RANK_MAX  = stm_pkg::RANK_MAX_DEF,
    parameter int MODES_MAX = stm_pkg::MODES_MAX_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data,
    stm_in_if.sink     in_ch,
    stm_out_if.source  out_ch
);
    import stm_pkg::*;

    localparam int RW  = (ROWS_MAX > 1) ? $clog2(ROWS_MAX) : 1;
    localparam int KW  = (RANK_MAX > 1) ? $clog2(RANK_MAX) : 1;
    localparam int OAW = RW + KW;
    localparam int FAW = 2 + RW + KW;
    localparam int ODEPTH = ROWS_MAX * RANK_MAX;
    localparam int FDEPTH = MODES_MAX * ROWS_MAX * RANK_MAX;
    localparam int RCW = $clog2(RANK_MAX + 1);

    // Configuration registers
    logic [2:0] num_modes_reg;
    logic [1:0] target_mode_reg;
    logic [4:0] rank_reg;
    logic [7:0] order_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_modes_reg   <= 3'd3;
            target_mode_reg <= 2'd0;
            rank_reg        <= 5'd16;
            order_reg       <= 8'd228;
        end
        else if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_NUM_MODES:     num_modes_reg   <= cfg_data[2:0];
                REG_TARGET_MODE:   target_mode_reg <= cfg_data[1:0];
                REG_RANK:          rank_reg        <= cfg_data[4:0];
                REG_PRODUCT_ORDER: order_reg       <= cfg_data;
                default:           ;
            endcase
        end
    end

    // Map a mode number into range
    function automatic logic [1:0] mode_mod(input logic [1:0] m);
        return (32'(m) >= MODES_MAX) ? 2'(32'(m) - MODES_MAX) : m;
    endfunction

    // Memories
    logic signed [31:0] fmem [FDEPTH];
    logic signed [31:0] omem [ODEPTH];
    logic               f_we, o_we;
    logic [FAW-1:0]     f_waddr, f_raddr;
    logic [OAW-1:0]     o_waddr, o_raddr;
    logic signed [31:0] f_wdata, o_wdata, f_rdata, o_rdata;

    always_ff @(posedge clk)
    begin
        if (f_we)
            fmem[f_waddr] <= f_wdata;
        f_rdata <= fmem[f_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (o_we)
            omem[o_waddr] <= o_wdata;
        o_rdata <= omem[o_raddr];
    end

    // Sequencer state
    state_t              state_reg, state_next;
    logic [9:0]          crd_reg [4];
    logic signed [31:0]  val_reg;
    logic [KW-1:0]       r_reg;
    logic [1:0]          step_reg;
    logic signed [31:0]  acc_reg;
    logic signed [63:0]  prod_reg;
    logic [OAW-1:0]      clr_reg;
    logic                ovalid_reg;
    logic signed [31:0]  odata_reg;

    // Derived item controls
    logic [2:0]     modes_use;
    logic [RCW-1:0] rank_use;
    logic [1:0]     cur_mode, tmode;
    logic [RW-1:0]  orow, frow;
    logic           last_step, last_r;

    assign modes_use = (num_modes_reg == 3'd4 && MODES_MAX >= 4) ? 3'd4 : 3'd3;
    assign rank_use  = (32'(rank_reg) > RANK_MAX) ? RCW'(RANK_MAX) : RCW'(rank_reg);
    assign cur_mode  = mode_mod(order_reg[2*(step_reg)+:2]);
    assign tmode     = mode_mod(target_mode_reg);
    assign orow      = RW'(crd_reg[tmode]);
    assign frow      = RW'(crd_reg[cur_mode]);
    assign last_step = ({1'b0, step_reg} == modes_use - 3'd1);
    assign last_r    = (RCW'(r_reg) + RCW'(1) >= rank_use);

    logic in_fire;
    assign in_fire     = in_ch.valid && in_ch.ready;
    assign in_ch.ready = (state_reg == ST_IDLE) &&
                         !(ovalid_reg && in_ch.op == OP_READ);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    case (op_t'(in_ch.op))
                        OP_NZ:    state_next = (rank_reg == 5'd0) ? ST_IDLE : ST_RDREQ;
                        OP_READ:  state_next = ST_READ;
                        OP_CLEAR: state_next = ST_CLEAR;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_CLEAR: state_next = (32'(clr_reg) == ODEPTH - 1) ? ST_IDLE : ST_CLEAR;
            ST_RDREQ: state_next = ST_FACT;
            ST_FACT:  state_next = ST_MUL;
            ST_MUL:   state_next = last_step ? ST_ACC : ST_RDREQ;
            ST_ACC:   state_next = last_r ? ST_IDLE : ST_RDREQ;
            ST_READ:  state_next = ST_OUT;
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // Memory controls
    always_comb
    begin
        f_we    = 1'b0;
        f_waddr = {mode_mod(in_ch.factor_select), RW'(in_ch.coord_0), KW'(in_ch.column)};
        f_wdata = in_ch.value;
        f_raddr = {cur_mode, frow, r_reg};
        o_we    = 1'b0;
        o_waddr = {orow, r_reg};
        o_wdata = sat32(64'(acc_reg) + 64'(o_rdata));
        o_raddr = (state_reg == ST_IDLE) ? {RW'(in_ch.coord_0), KW'(in_ch.column)}
                                         : {orow, r_reg};
        case (state_reg)
            ST_IDLE:  f_we = in_fire && in_ch.op == OP_LOAD;
            ST_CLEAR:
            begin
                o_we    = 1'b1;
                o_waddr = clr_reg;
                o_wdata = '0;
            end
            ST_ACC:   o_we = 1'b1;
            default:  ;
        endcase
    end

    // Registers; reset starts a clearing pass over the output memory
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_CLEAR;
            ovalid_reg <= 1'b0;
            clr_reg    <= '0;
            r_reg      <= '0;
            step_reg   <= 2'd1;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_OUT)
                ovalid_reg <= 1'b1;
            else if (out_ch.ready)
                ovalid_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    clr_reg  <= '0;
                    r_reg    <= '0;
                    step_reg <= 2'd1;
                end
                ST_CLEAR: clr_reg <= clr_reg + OAW'(1);
                ST_MUL:   step_reg <= last_step ? 2'd1 : step_reg + 2'd1;
                ST_ACC:   r_reg <= r_reg + KW'(1);
                default:  ;
            endcase
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            crd_reg[0] <= in_ch.coord_0;
            crd_reg[1] <= in_ch.coord_1;
            crd_reg[2] <= in_ch.coord_2;
            crd_reg[3] <= in_ch.coord_3;
            val_reg    <= in_ch.value;
            acc_reg    <= in_ch.value;
        end
        if (state_reg == ST_FACT)
            prod_reg <= 64'(acc_reg) * 64'(f_rdata);
        if (state_reg == ST_MUL)
            acc_reg <= qscale(prod_reg);
        if (state_reg == ST_ACC)
            acc_reg <= val_reg;
        // Capture the element read at the accepting edge
        if (state_reg == ST_READ)
            odata_reg <= o_rdata;
    end

    assign out_ch.valid      = ovalid_reg;
    assign out_ch.read_value = odata_reg;

    // Checks
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> !in_ch.ready)
        else $error("item accepted while busy");
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && !out_ch.ready) |=> out_ch.valid)
        else $error("result dropped");
    a_read_out: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_READ) |=> (state_reg == ST_OUT))
        else $error("read sequence broken");
    a_clear_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR && 32'(clr_reg) == ODEPTH - 1) |=> (state_reg == ST_IDLE))
        else $error("clear overran");

endmodule

@@ dv/stm_tb_if.sv @@
// Testbench-side note: the channel interfaces come from design/stm_if.sv.
// This file holds the item record used by the testbench; depends on stm_pkg.
package stm_tb_pkg;
    import stm_pkg::*;

    typedef struct {
        op_t              op;
        logic [1:0]       factor_select;
        logic [3:0]       column;
        logic [9:0]       coord[4];
        logic signed [31:0] value;
    } mttkrp_item_t;
endpackage

@@ dv/testbench.sv @@
// Testbench for sparse_tensor_mttkrp: drives load, nonzero, read and clear items
// and checks read results against an in-bench MTTKRP predictor.
// Depends on stm_pkg, stm_tb_pkg, the stm interfaces and the RTL.
module testbench;
    import stm_pkg::*;
    import stm_tb_pkg::*;

    localparam int ROWS = 1024;
    localparam int RNK  = 16;
    localparam int CYCLE_LIMIT = 4000000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [7:0] cfg_data = '0;

    stm_in_if  in_ch();
    stm_out_if out_ch();

    sparse_tensor_mttkrp dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
        .cfg_data(cfg_data), .in_ch(in_ch), .out_ch(out_ch)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // predictor state
    logic signed [31:0] factor_mem[4][ROWS][RNK];
    logic signed [31:0] output_mem[ROWS][RNK];
    logic [2:0] cur_modes;
    logic [1:0] cur_target;
    logic [4:0] cur_rank;
    logic [7:0] cur_order;

    mttkrp_item_t        pending_items[$];
    logic signed [31:0]  expected_reads[$];
    int  send_idle_pct = 0;
    int  recv_stall_pct = 0;
    int  errors = 0;
    int  n_reads = 0;
    int  n_nz = 0;
    longint cycles = 0;

    function automatic logic signed [31:0] clamp32(input logic signed [63:0] v);
        if (v > 64'sd2147483647) return 32'sh7fffffff;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        return clamp32(p >>> 16);
    endfunction

    // Apply one accepted item to the predictor.
    task automatic predict_item(input mttkrp_item_t it);
        int nm;
        int rk;
        int m;
        logic [9:0] orow;
        logic signed [31:0] acc;
        nm = (cur_modes == 3'd4) ? 4 : 3;
        rk = (cur_rank > RNK) ? RNK : int'(cur_rank);
        case (it.op)
            OP_LOAD:
                factor_mem[it.factor_select][it.coord[0]][it.column] = it.value;
            OP_READ:
                expected_reads.push_back(output_mem[it.coord[0]][it.column]);
            OP_CLEAR:
                foreach (output_mem[i, j]) output_mem[i][j] = '0;
            default:
            begin
                orow = it.coord[cur_target];
                for (int r = 0; r < rk; r++)
                begin
                    acc = it.value;
                    for (int k = 1; k < nm; k++)
                    begin
                        m = (cur_order >> (2 * k)) & 3;
                        acc = fx_mul(acc, factor_mem[m][it.coord[m]][r]);
                    end
                    output_mem[orow][r] = clamp32(64'(output_mem[orow][r]) + 64'(acc));
                end
            end
        endcase
    endtask

    // Driver: present queued items, advance on acceptance.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.op <= OP_LOAD;
            in_ch.factor_select <= '0;
            in_ch.column <= '0;
            in_ch.coord_0 <= '0;
            in_ch.coord_1 <= '0;
            in_ch.coord_2 <= '0;
            in_ch.coord_3 <= '0;
            in_ch.value <= '0;
        end
        else
        begin
            if (in_ch.valid && in_ch.ready)
                predict_item(pending_items.pop_front());
            if ((!in_ch.valid || in_ch.ready) &&
                pending_items.size() > 0 &&
                ($urandom_range(99) >= send_idle_pct))
            begin
                // next item is at front after the pop above
                in_ch.valid <= 1'b1;
                in_ch.op <= pending_items[0].op;
                in_ch.factor_select <= pending_items[0].factor_select;
                in_ch.column <= pending_items[0].column;
                in_ch.coord_0 <= pending_items[0].coord[0];
                in_ch.coord_1 <= pending_items[0].coord[1];
                in_ch.coord_2 <= pending_items[0].coord[2];
                in_ch.coord_3 <= pending_items[0].coord[3];
                in_ch.value <= pending_items[0].value;
            end
            else if (in_ch.ready)
                in_ch.valid <= 1'b0;
        end
    end

    // Monitor: check each accepted read result against the oldest expectation.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ch.ready <= 1'b0;
        else
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_reads.size() == 0)
                begin
                    $error("read_value: unexpected result %0d", out_ch.read_value);
                    errors++;
                end
                else
                begin
                    logic signed [31:0] exp_v;
                    exp_v = expected_reads.pop_front();
                    n_reads++;
                    if (out_ch.read_value !== exp_v)
                    begin
                        $error("read_value: expected %0d, actual %0d", exp_v,
                               out_ch.read_value);
                        errors++;
                    end
                end
            end
            out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    function automatic mttkrp_item_t make_item(input op_t op, input int sel, input int col,
                                               input int c0, input int c1, input int c2,
                                               input int c3, input logic signed [31:0] v);
        mttkrp_item_t it;
        it.op = op;
        it.factor_select = 2'(sel);
        it.column = 4'(col);
        it.coord[0] = 10'(c0);
        it.coord[1] = 10'(c1);
        it.coord[2] = 10'(c2);
        it.coord[3] = 10'(c3);
        it.value = v;
        return it;
    endfunction

    // Rows used for nonzeros; every factor element on them gets loaded first.
    int hot_rows[4];

    function automatic logic signed [31:0] rand_q();
        case ($urandom_range(5))
            0: return 32'sh7fffffff;
            1: return 32'sh80000000;
            2: return $urandom;
            default: return $signed(32'($urandom_range(131072))) - 32'sd65536;
        endcase
    endfunction

    task automatic wait_drained();
        while (pending_items.size() != 0 || in_ch.valid || expected_reads.size() != 0)
            @(posedge clk);
        repeat (20000) @(posedge clk);  // cover a trailing clear pass
    endtask

    task automatic write_reg(input reg_idx_t idx, input logic [7:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_NUM_MODES:   cur_modes = val[2:0];
            REG_TARGET_MODE: cur_target = val[1:0];
            REG_RANK:        cur_rank = val[4:0];
            default:         cur_order = val;
        endcase
    endtask

    function automatic int pick_coord(input int m);
        return ($urandom_range(3) == 0) ? hot_rows[m] ^ 1 : hot_rows[m];
    endfunction

    // Queue a random phase of items on the loaded rows.
    task automatic queue_random(input int count);
        op_t op;
        for (int n = 0; n < count; n++)
        begin
            case ($urandom_range(9))
                0, 1:    op = OP_LOAD;
                2, 3, 4, 5: op = OP_NZ;
                9:       op = ($urandom_range(7) == 0) ? OP_CLEAR : OP_READ;
                default: op = OP_READ;
            endcase
            if (op == OP_NZ) n_nz++;
            pending_items.push_back(make_item(op, $urandom_range(3), $urandom_range(15),
                pick_coord(0), pick_coord(1), pick_coord(2), pick_coord(3), rand_q()));
            if (op == OP_NZ && $urandom_range(1))
                pending_items.push_back(make_item(OP_READ, 0, $urandom_range(15),
                    pick_coord(cur_target), 0, 0, 0, $urandom));
        end
    endtask

    initial
    begin
        logic [7:0] ord;
        cur_modes = 3; cur_target = 0; cur_rank = 16; cur_order = 8'd228;
        foreach (output_mem[i, j]) output_mem[i][j] = '0;
        foreach (factor_mem[m, i, j]) factor_mem[m][i][j] = '0;
        for (int m = 0; m < 4; m++) hot_rows[m] = $urandom_range(1, 1022) & ~1;
        hot_rows[0] = 1022;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // directed: load all factor rows used, then extremes, reads, clear
        for (int m = 0; m < 4; m++)
            for (int h = 0; h < 2; h++)
                for (int c = 0; c < RNK; c++)
                    pending_items.push_back(make_item(OP_LOAD, m, c, hot_rows[m] ^ h,
                        0, 0, 0, (c == 0) ? 32'sh7fffffff :
                                 (c == 1) ? 32'sh80000000 : rand_q()));
        pending_items.push_back(make_item(OP_NZ, 0, 0, hot_rows[0], hot_rows[1],
            hot_rows[2], hot_rows[3], 32'sh7fffffff));
        pending_items.push_back(make_item(OP_NZ, 0, 0, hot_rows[0], hot_rows[1],
            hot_rows[2], hot_rows[3], 32'sh80000000));
        pending_items.push_back(make_item(OP_READ, 0, 0, hot_rows[0], 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_READ, 0, 15, hot_rows[0], 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_READ, 3, 15, 1023, 1023, 1023, 1023, -1));
        pending_items.push_back(make_item(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0));
        pending_items.push_back(make_item(OP_READ, 0, 1, hot_rows[0], 0, 0, 0, 0));

        // random phases across settings and idling modes
        for (int ph = 0; ph < 12; ph++)
        begin
            wait_drained();
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 82; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 82; end
                default: begin send_idle_pct = 14; recv_stall_pct = 14; end
            endcase
            write_reg(REG_NUM_MODES, (ph == 0) ? 8'd4 : (ph == 1) ? 8'd7 :
                                     (ph == 2) ? 8'd0 : 8'($urandom_range(7)));
            write_reg(REG_TARGET_MODE, 8'($urandom_range(3)));
            write_reg(REG_RANK, (ph == 0) ? 8'd0 : (ph == 1) ? 8'd31 : (ph == 2) ? 8'd1 :
                                8'($urandom_range(31)));
            ord = (ph == 3) ? 8'd0 : (ph == 4) ? 8'd255 : 8'($urandom);
            write_reg(REG_PRODUCT_ORDER, ord);
            queue_random(45);
        end
        wait_drained();
        $display("Covered %0d nonzero items and %0d checked reads over 12 register settings.",
                 n_nz, n_reads);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
